### rtl/core/cwac_pkg.sv
// shared types, constants and helpers of the card whitelist access controller
`default_nettype none
package cwac_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int UID_MAX_BYTES = 7;
	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int UID_W = 56;
	localparam int LEN_W = 3;
	localparam int ENTRY_W = UID_W + LEN_W;

	localparam logic [7:0] TIMEOUT_RST = 8'd30;
	localparam logic [15:0] IDLE_LIMIT_RST = 16'd6000;

	localparam logic [2:0] ADDR_TIMEOUT = 3'd0;
	localparam logic [2:0] ADDR_IDLE_LIMIT = 3'd4;

	typedef enum logic [2:0] {
		OUT_NONE = 3'd0,
		OUT_GRANTED = 3'd1,
		OUT_DENIED = 3'd2,
		OUT_ADDED = 3'd3,
		OUT_REMOVED = 3'd4,
		OUT_UNCHANGED = 3'd5,
		OUT_FULL = 3'd6,
		OUT_SKIPPED = 3'd7
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} ctrl_state_t;

	// write or clear of one table entry
	typedef struct packed {
		logic write_en;
		logic clear_en;
		logic [IDX_W-1:0] idx;
		logic [UID_W-1:0] id;
		logic [LEN_W-1:0] len;
	} tbl_cmd_t;

	// what one scan of the table found
	typedef struct packed {
		logic hit;
		logic [IDX_W-1:0] hit_idx;
		logic free;
		logic [IDX_W-1:0] free_idx;
	} tbl_res_t;

	// keeps the low len bytes of a uid
	function automatic logic [UID_W-1:0] uid_mask(input logic [LEN_W-1:0] len);
		logic [UID_W-1:0] m;
		m = '0;
		for (int b = 0; b < UID_MAX_BYTES; b++) begin
			if (LEN_W'(b) < len) begin
				m[8*b +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/core/card_whitelist_access_controller.sv
// Card whitelist access controller top level: mode control, config registers and result register.
// Each item is one poll. A poll with no usable card, a restart or a skipped card goes from ST_IDLE
// straight to ST_EMIT, where its result is loaded into the output register, and the block then
// returns to ST_IDLE for the next item. A poll whose card must be looked up first stays in ST_SCAN
// while it scans the whole 16-entry table through the single read port of the table ram, one entry
// per cycle, then goes to ST_EMIT. One item is in work at a time; in_stall is high while it is.
// A finished result waits in the output register, and the next item may be accepted
// meanwhile; a result that finds the output register still stalled waits until it drains.
// The table keeps its contents across idle restarts; uid entries come up undefined and only
// their valid bits are cleared by reset.
`default_nettype none
module card_whitelist_access_controller import cwac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic learn_button,
	input wire logic forget_button,
	input wire logic card_present,
	input wire logic [UID_W-1:0] card_uid,
	input wire logic [LEN_W-1:0] uid_bytes,
	output logic out_valid,
	input wire logic out_stall,
	output logic learn_lamp,
	output logic forget_lamp,
	output logic door_pulse,
	output logic [2:0] outcome,
	output logic in_programming,
	output logic restarted,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	ctrl_state_t state_q, state_nxt;
	logic accept, finish, emit, go_scan;

	logic [7:0] timeout_q;
	logic [15:0] idle_limit_q;

	logic prog_q, learn_sel_q, skip_q, lamp_learn_q, lamp_forget_q;
	logic [7:0] timer_q;
	logic [15:0] idle_q;

	logic m_prog, m_learn_sel, m_lamp_learn, m_lamp_forget;
	logic [7:0] m_timer;
	logic [15:0] m_idle;
	logic restart, card_ok;
	logic [UID_W-1:0] m_id;

	logic [UID_W-1:0] id_q;
	logic [LEN_W-1:0] len_q;
	outcome_t res_outcome_q, fin_outcome;
	logic res_restart_q;

	logic out_valid_q, out_learn_q, out_forget_q, out_prog_q, out_restart_q;
	outcome_t out_outcome_q;

	tbl_cmd_t tbl_cmd;
	tbl_res_t tbl_res;
	logic tbl_done;

	// config port
	assign pready = 1'b1;

	always_comb begin
		unique case (paddr[2])
			1'b0: prdata = {24'd0, timeout_q};
			1'b1: prdata = {16'd0, idle_limit_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			idle_limit_q <= IDLE_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == ADDR_IDLE_LIMIT[2]) begin
				idle_limit_q <= pwdata[15:0];
			end else begin
				timeout_q <= pwdata[7:0];
			end
		end
	end

	// mode update for the poll being accepted
	always_comb begin
		m_timer = prog_q ? timer_q + 8'd1 : timer_q;
		m_prog = prog_q;
		m_learn_sel = learn_sel_q;
		m_lamp_learn = lamp_learn_q;
		m_lamp_forget = lamp_forget_q;
		if (m_timer == timeout_q) begin
			m_timer = '0;
			m_prog = 1'b0;
			m_lamp_learn = 1'b0;
			m_lamp_forget = 1'b0;
		end
		if (learn_button) begin
			m_timer = '0;
			m_prog = 1'b1;
			m_lamp_learn = 1'b1;
			m_lamp_forget = 1'b0;
			m_learn_sel = 1'b1;
		end
		if (forget_button) begin
			m_timer = '0;
			m_prog = 1'b1;
			m_lamp_forget = 1'b1;
			m_lamp_learn = 1'b0;
			m_learn_sel = 1'b0;
		end
		m_idle = (!m_prog && idle_q != '1) ? idle_q + 16'd1 : idle_q;
		restart = m_idle > idle_limit_q;
		card_ok = card_present && uid_bytes != '0 && uid_bytes <= LEN_W'(UID_MAX_BYTES);
		m_id = card_uid & uid_mask(uid_bytes);
		go_scan = !restart && card_ok && (m_prog || !skip_q);
	end

	// control fsm
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		accept = 1'b0;
		finish = 1'b0;
		emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					accept = 1'b1;
					state_nxt = go_scan ? ST_SCAN : ST_EMIT;
				end
			end
			ST_SCAN: begin
				if (tbl_done) begin
					finish = 1'b1;
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// outcome and table update once the scan is done
	always_comb begin
		tbl_cmd = '0;
		tbl_cmd.id = id_q;
		tbl_cmd.len = len_q;
		fin_outcome = OUT_NONE;
		if (prog_q) begin
			if (learn_sel_q) begin
				if (tbl_res.hit) begin
					fin_outcome = OUT_UNCHANGED;
				end else if (tbl_res.free) begin
					fin_outcome = OUT_ADDED;
					tbl_cmd.write_en = finish;
					tbl_cmd.idx = tbl_res.free_idx;
				end else begin
					fin_outcome = OUT_FULL;
				end
			end else begin
				if (tbl_res.hit) begin
					fin_outcome = OUT_REMOVED;
					tbl_cmd.clear_en = finish;
					tbl_cmd.idx = tbl_res.hit_idx;
				end else begin
					fin_outcome = OUT_UNCHANGED;
				end
			end
		end else begin
			fin_outcome = tbl_res.hit ? OUT_GRANTED : OUT_DENIED;
		end
	end

	cwac_table u_table (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept && go_scan),
		.key_id(id_q),
		.key_len(len_q),
		.cmd(tbl_cmd),
		.done(tbl_done),
		.res(tbl_res)
	);

	// mode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q <= 1'b0;
			learn_sel_q <= 1'b0;
			timer_q <= '0;
			idle_q <= '0;
			skip_q <= 1'b0;
			lamp_learn_q <= 1'b0;
			lamp_forget_q <= 1'b0;
			res_outcome_q <= OUT_NONE;
			res_restart_q <= 1'b0;
		end else if (accept) begin
			if (restart) begin
				prog_q <= 1'b0;
				learn_sel_q <= 1'b0;
				timer_q <= '0;
				idle_q <= '0;
				skip_q <= 1'b0;
				lamp_learn_q <= 1'b0;
				lamp_forget_q <= 1'b0;
				res_outcome_q <= OUT_NONE;
				res_restart_q <= 1'b1;
			end else begin
				prog_q <= m_prog;
				learn_sel_q <= m_learn_sel;
				timer_q <= m_timer;
				idle_q <= m_idle;
				lamp_learn_q <= m_lamp_learn;
				lamp_forget_q <= m_lamp_forget;
				res_restart_q <= 1'b0;
				// first card after programming is ignored
				if (card_ok && !m_prog && skip_q) begin
					skip_q <= 1'b0;
					res_outcome_q <= OUT_SKIPPED;
				end else begin
					res_outcome_q <= OUT_NONE;
				end
			end
		end else if (finish) begin
			res_outcome_q <= fin_outcome;
			if (prog_q) begin
				skip_q <= 1'b1;
			end
			if (fin_outcome == OUT_ADDED) begin
				prog_q <= 1'b0;
				lamp_learn_q <= 1'b0;
			end
			if (fin_outcome == OUT_REMOVED) begin
				prog_q <= 1'b0;
				lamp_forget_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_q <= m_id;
			len_q <= uid_bytes;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_learn_q <= lamp_learn_q;
			out_forget_q <= lamp_forget_q;
			out_prog_q <= prog_q;
			out_outcome_q <= res_outcome_q;
			out_restart_q <= res_restart_q;
		end
	end

	assign out_valid = out_valid_q;
	assign learn_lamp = out_learn_q;
	assign forget_lamp = out_forget_q;
	assign outcome = out_outcome_q;
	assign door_pulse = (out_outcome_q == OUT_GRANTED);
	assign in_programming = out_prog_q;
	assign restarted = out_restart_q;

endmodule
`default_nettype wire

### rtl/core/cwac_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module cwac_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/core/cwac_table.sv
// card table: uid ram, valid bits and the sequential scan engine
`default_nettype none
module cwac_table import cwac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [UID_W-1:0] key_id,
	input wire logic [LEN_W-1:0] key_len,
	input wire tbl_cmd_t cmd,
	output logic done,
	output tbl_res_t res
);

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic busy_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic cmp_vld_s1;
	logic cmp_last_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic done_q;
	tbl_res_t res_q;
	logic [ENTRY_W-1:0] rdata;
	logic match;
	logic empty;

	cwac_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk(clk),
		.we(cmd.write_en),
		.waddr(cmd.idx),
		.wdata({cmd.len, cmd.id}),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	assign match = valid_q[cmp_idx_s1] && (rdata == {key_len, key_id});
	assign empty = !valid_q[cmp_idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			busy_q <= 1'b0;
			rd_idx_q <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_last_s1 <= 1'b0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			if (cmd.write_en) begin
				valid_q[cmd.idx] <= 1'b1;
			end
			if (cmd.clear_en) begin
				valid_q[cmd.idx] <= 1'b0;
			end
			done_q <= cmp_vld_s1 && cmp_last_s1;
			cmp_vld_s1 <= busy_q;
			cmp_last_s1 <= busy_q && (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));
			if (start) begin
				busy_q <= 1'b1;
				rd_idx_q <= '0;
				res_q <= '0;
			end else if (busy_q) begin
				if (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
					busy_q <= 1'b0;
				end
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			// keep the first hit and the first free slot
			if (cmp_vld_s1) begin
				if (match && !res_q.hit) begin
					res_q.hit <= 1'b1;
					res_q.hit_idx <= cmp_idx_s1;
				end
				if (empty && !res_q.free) begin
					res_q.free <= 1'b1;
					res_q.free_idx <= cmp_idx_s1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= rd_idx_q;
	end

	assign done = done_q;
	assign res = res_q;

endmodule
`default_nettype wire

### rtl/core/cwac_checker.sv
// port-level checks of the card whitelist access controller and their bind
`default_nettype none
module cwac_checker import cwac_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic learn_lamp,
	input wire logic forget_lamp,
	input wire logic door_pulse,
	input wire logic [2:0] outcome,
	input wire logic in_programming,
	input wire logic restarted
);

	// one item at a time: acceptance closes the input
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an item");

	a_door_granted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && door_pulse |-> outcome == OUT_GRANTED)
		else $error("door pulse without a granted outcome");

	a_restart_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && restarted |-> outcome == OUT_NONE && !learn_lamp && !forget_lamp
			&& !in_programming)
		else $error("restart result carries mode state");

	// exactly one lamp lit while programming
	a_lamp_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(learn_lamp && forget_lamp) && ((learn_lamp || forget_lamp) == in_programming))
		else $error("lamps disagree with programming mode");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(restarted))
		else $error("stalled result changed");

endmodule

bind card_whitelist_access_controller cwac_checker u_cwac_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.learn_lamp(learn_lamp),
	.forget_lamp(forget_lamp),
	.door_pulse(door_pulse),
	.outcome(outcome),
	.in_programming(in_programming),
	.restarted(restarted)
);
`default_nettype wire

### sim/card_whitelist_access_controller_test.sv
// testbench of the card whitelist access controller: directed and random polls checked against a predictor
`default_nettype none
module card_whitelist_access_controller_test;
	import cwac_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int POOL_SIZE = 24;

	typedef struct packed {
		bit learn;
		bit forget;
		bit present;
		bit [UID_W-1:0] uid;
		bit [LEN_W-1:0] len;
	} poll_t;

	typedef struct packed {
		logic learn_lamp;
		logic forget_lamp;
		logic door;
		outcome_t outcome;
		logic in_prog;
		logic restarted;
	} verdict_t;

	class whitelist_scoreboard;
		bit [UID_W-1:0] ids[TABLE_ENTRIES];
		bit [LEN_W-1:0] lens[TABLE_ENTRIES];
		bit used[TABLE_ENTRIES];
		bit prog_on;
		bit learn_mode;
		bit [7:0] prog_timer;
		bit [15:0] idle_cnt;
		bit skip_card;
		bit lamp_l;
		bit lamp_f;
		bit [7:0] timeout_polls;
		bit [15:0] restart_limit;
		verdict_t expected_verdicts[$];
		int fails;
		int results_seen;

		function new();
			foreach (used[i]) used[i] = 0;
			fails = 0;
			results_seen = 0;
			timeout_polls = TIMEOUT_RST;
			restart_limit = IDLE_LIMIT_RST;
			clear_modes();
		endfunction

		static function bit [UID_W-1:0] id_mask(bit [LEN_W-1:0] n);
			bit [63:0] m;
			m = (64'd1 << (8 * n)) - 64'd1;
			return m[UID_W-1:0];
		endfunction

		function void clear_modes();
			prog_on = 0;
			learn_mode = 0;
			prog_timer = 0;
			idle_cnt = 0;
			skip_card = 0;
			lamp_l = 0;
			lamp_f = 0;
		endfunction

		function int lookup(bit [UID_W-1:0] key, bit [LEN_W-1:0] n);
			int hit;
			hit = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (hit < 0 && used[i] && lens[i] == n && ids[i] == key) hit = i;
			end
			return hit;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		task report(string msg);
			fails++;
			$display("mismatch: %s", msg);
		endtask

		// works out the verdict of one accepted poll and queues it
		function void note_poll(poll_t p);
			verdict_t v;
			bit [UID_W-1:0] key;
			int hit;
			int spot;
			v = '0;
			v.outcome = OUT_NONE;
			if (prog_on) prog_timer = prog_timer + 8'd1;
			if (prog_timer == timeout_polls) begin
				prog_timer = 0;
				prog_on = 0;
				lamp_l = 0;
				lamp_f = 0;
			end
			if (p.learn) begin
				prog_timer = 0;
				prog_on = 1;
				lamp_l = 1;
				lamp_f = 0;
				learn_mode = 1;
			end
			if (p.forget) begin
				prog_timer = 0;
				prog_on = 1;
				lamp_f = 1;
				lamp_l = 0;
				learn_mode = 0;
			end
			if (!prog_on && idle_cnt != 16'hFFFF) idle_cnt = idle_cnt + 16'd1;
			if (idle_cnt > restart_limit) begin
				// mode state back to reset, table kept, card not looked at
				clear_modes();
				v.restarted = 1;
				expected_verdicts.push_back(v);
				return;
			end
			if (p.present && p.len != 0 && p.len <= UID_MAX_BYTES) begin
				key = p.uid & id_mask(p.len);
				hit = lookup(key, p.len);
				if (prog_on) begin
					skip_card = 1;
					if (learn_mode) begin
						if (hit >= 0) begin
							v.outcome = OUT_UNCHANGED;
						end else begin
							spot = -1;
							for (int i = 0; i < TABLE_ENTRIES; i++) begin
								if (spot < 0 && !used[i]) spot = i;
							end
							if (spot < 0) begin
								v.outcome = OUT_FULL;
							end else begin
								ids[spot] = key;
								lens[spot] = p.len;
								used[spot] = 1;
								prog_on = 0;
								lamp_l = 0;
								v.outcome = OUT_ADDED;
							end
						end
					end else if (hit >= 0) begin
						used[hit] = 0;
						prog_on = 0;
						lamp_f = 0;
						v.outcome = OUT_REMOVED;
					end else begin
						v.outcome = OUT_UNCHANGED;
					end
				end else if (skip_card) begin
					skip_card = 0;
					v.outcome = OUT_SKIPPED;
				end else if (hit >= 0) begin
					v.outcome = OUT_GRANTED;
					v.door = 1;
				end else begin
					v.outcome = OUT_DENIED;
				end
			end
			v.learn_lamp = lamp_l;
			v.forget_lamp = lamp_f;
			v.in_prog = prog_on;
			expected_verdicts.push_back(v);
		endfunction

		task check_result(verdict_t got);
			verdict_t exp_v;
			results_seen++;
			if (expected_verdicts.size() == 0) begin
				report($sformatf("result %0d arrived with no poll waiting", results_seen));
				return;
			end
			exp_v = expected_verdicts.pop_front();
			if (got.learn_lamp !== exp_v.learn_lamp)
				report($sformatf("result %0d learn_lamp %b, want %b", results_seen,
					got.learn_lamp, exp_v.learn_lamp));
			if (got.forget_lamp !== exp_v.forget_lamp)
				report($sformatf("result %0d forget_lamp %b, want %b", results_seen,
					got.forget_lamp, exp_v.forget_lamp));
			if (got.door !== exp_v.door)
				report($sformatf("result %0d door_pulse %b, want %b", results_seen,
					got.door, exp_v.door));
			if (got.outcome !== exp_v.outcome)
				report($sformatf("result %0d outcome %0d, want %0d", results_seen,
					got.outcome, exp_v.outcome));
			if (got.in_prog !== exp_v.in_prog)
				report($sformatf("result %0d in_programming %b, want %b", results_seen,
					got.in_prog, exp_v.in_prog));
			if (got.restarted !== exp_v.restarted)
				report($sformatf("result %0d restarted %b, want %b", results_seen,
					got.restarted, exp_v.restarted));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic learn_button;
	logic forget_button;
	logic card_present;
	logic [UID_W-1:0] card_uid;
	logic [LEN_W-1:0] uid_bytes;
	logic out_valid;
	logic out_stall;
	logic learn_lamp;
	logic forget_lamp;
	logic door_pulse;
	logic [2:0] outcome;
	logic in_programming;
	logic restarted;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	whitelist_scoreboard sb;
	verdict_t seen;
	int cycles;
	int sent_items;
	int stall_left;
	bit quiet;
	bit [UID_W-1:0] pool_uid[POOL_SIZE];
	bit [LEN_W-1:0] pool_len[POOL_SIZE];

	card_whitelist_access_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.learn_button(learn_button),
		.forget_button(forget_button),
		.card_present(card_present),
		.card_uid(card_uid),
		.uid_bytes(uid_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.learn_lamp(learn_lamp),
		.forget_lamp(forget_lamp),
		.door_pulse(door_pulse),
		.outcome(outcome),
		.in_programming(in_programming),
		.restarted(restarted),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic bit [UID_W-1:0] rand_uid();
		return UID_W'({$urandom, $urandom});
	endfunction

	// card of a pool identity, optionally with junk above its length
	function automatic poll_t pool_card(int k, bit noise);
		poll_t p;
		bit [UID_W-1:0] m;
		m = whitelist_scoreboard::id_mask(pool_len[k]);
		p = '0;
		p.present = 1;
		p.len = pool_len[k];
		p.uid = pool_uid[k] & m;
		if (noise) p.uid = p.uid | (rand_uid() & ~m);
		return p;
	endfunction

	function automatic poll_t no_card();
		poll_t p;
		p = '0;
		p.uid = rand_uid();
		p.len = LEN_W'($urandom_range(0, 7));
		if ($urandom_range(0, 2) == 0) begin
			p.present = 1;
			p.len = 0;
		end
		return p;
	endfunction

	function automatic poll_t press(bit l, bit f);
		poll_t p;
		p = no_card();
		p.present = 0;
		p.learn = l;
		p.forget = f;
		return p;
	endfunction

	task automatic send_poll(input poll_t p);
		int gap;
		@(negedge clk);
		learn_button = p.learn;
		forget_button = p.forget;
		card_present = p.present;
		card_uid = p.uid;
		uid_bytes = p.len;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_poll(p);
		sent_items++;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// the last item is already taken, so valid drops before waiting
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [2:0] a, input logic [31:0] d,
			output logic [31:0] rd);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = a;
		pwdata = d;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// registers are only touched with nothing in flight
	task automatic set_config(input bit [7:0] polls, input bit [15:0] limit);
		logic [31:0] rd;
		drain();
		apb_access(1'b1, ADDR_TIMEOUT, {24'd0, polls}, rd);
		sb.timeout_polls = polls;
		apb_access(1'b1, ADDR_IDLE_LIMIT, {16'd0, limit}, rd);
		sb.restart_limit = limit;
		apb_access(1'b0, ADDR_TIMEOUT, 32'd0, rd);
		if (rd !== {24'd0, polls})
			sb.report($sformatf("mode_timeout_polls read %h, want %h", rd, polls));
		apb_access(1'b0, ADDR_IDLE_LIMIT, 32'd0, rd);
		if (rd !== {16'd0, limit})
			sb.report($sformatf("idle_restart_limit read %h, want %h", rd, limit));
	endtask

	// mode press and card, either in one poll or split by empty polls
	task automatic mode_burst(input bit f, input int k);
		poll_t p;
		p = pool_card(k, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0) begin
			p.learn = !f;
			p.forget = f;
			send_poll(p);
		end else begin
			send_poll(press(!f, f));
			repeat ($urandom_range(0, 2)) send_poll(no_card());
			send_poll(p);
		end
	endtask

	task automatic random_burst();
		int r;
		int k;
		poll_t p;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, POOL_SIZE - 1);
		if (r < 30) begin
			send_poll(pool_card(k, 1'($urandom_range(0, 1))));
		end else if (r < 52) begin
			mode_burst(1'b0, k);
		end else if (r < 67) begin
			mode_burst(1'b1, k);
		end else if (r < 77) begin
			send_poll(no_card());
		end else if (r < 87) begin
			p.learn = 1'($urandom_range(0, 1));
			p.forget = 1'($urandom_range(0, 1));
			p.present = 1'($urandom_range(0, 1));
			p.uid = rand_uid();
			p.len = LEN_W'($urandom_range(0, 7));
			send_poll(p);
		end else if (r < 92) begin
			p = pool_card(k, 1'b1);
			p.learn = 1;
			p.forget = 1;
			send_poll(p);
		end else begin
			p = '0;
			p.present = 1;
			p.uid = rand_uid();
			p.len = LEN_W'($urandom_range(1, 7));
			send_poll(p);
		end
	endtask

	task automatic run_random(input int n);
		int target;
		target = sent_items + n;
		while (sent_items < target) begin
			if ($urandom_range(0, 24) == 0) quiet = !quiet;
			// hold off until the block has handed back everything
			if ($urandom_range(0, 79) == 0) drain();
			random_burst();
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			seen.learn_lamp = learn_lamp;
			seen.forget_lamp = forget_lamp;
			seen.door = door_pulse;
			seen.outcome = outcome_t'(outcome);
			seen.in_prog = in_programming;
			seen.restarted = restarted;
			sb.check_result(seen);
		end
	end

	initial begin
		poll_t p;
		sb = new();
		cycles = 0;
		sent_items = 0;
		stall_left = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		learn_button = 1'b0;
		forget_button = 1'b0;
		card_present = 1'b0;
		card_uid = '0;
		uid_bytes = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_len[i] = LEN_W'($urandom_range(1, 7));
			pool_uid[i] = rand_uid();
		end
		pool_len[0] = 4;
		pool_len[1] = 7;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed polls under the reset settings
		send_poll('0);
		send_poll(pool_card(0, 0));
		p = pool_card(0, 0);
		p.learn = 1;
		send_poll(p);
		send_poll(pool_card(0, 0));
		send_poll(pool_card(0, 0));
		send_poll(pool_card(0, 1));
		p = pool_card(0, 0);
		p.len = 5;
		send_poll(p);
		send_poll(press(1, 0));
		send_poll(pool_card(0, 1));
		p = '0;
		p.present = 1;
		p.uid = '1;
		p.len = 7;
		send_poll(p);
		send_poll(press(0, 1));
		send_poll(pool_card(1, 0));
		send_poll(pool_card(0, 0));
		send_poll(pool_card(0, 0));
		send_poll(pool_card(0, 0));
		p = '0;
		p.learn = 1;
		p.forget = 1;
		p.present = 1;
		p.uid = '1;
		send_poll(p);
		p = '0;
		p.present = 1;
		p.len = 1;
		send_poll(p);
		p = '0;
		p.learn = 1;
		p.forget = 1;
		p.present = 1;
		p.uid = '1;
		p.len = 7;
		send_poll(p);
		p.learn = 0;
		p.forget = 0;
		p.present = 0;
		send_poll(p);
		p = '0;
		p.present = 1;
		p.len = 1;
		send_poll(p);
		send_poll(p);

		set_config(8'd1, 16'd65535);
		run_random(150);
		set_config(8'd255, 16'd1);
		run_random(100);
		set_config(8'd3, 16'd20);
		run_random(200);
		set_config(8'($urandom_range(2, 10)), 16'($urandom_range(5, 80)));
		run_random(250);
		set_config(TIMEOUT_RST, IDLE_LIMIT_RST);
		run_random(150);

		@(negedge clk);
		in_valid = 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

### sim.f
rtl/core/cwac_pkg.sv
rtl/core/cwac_ram.sv
rtl/core/cwac_table.sv
rtl/core/card_whitelist_access_controller.sv
rtl/core/cwac_checker.sv
sim/card_whitelist_access_controller_test.sv
